// ----- rtl/dtf_pkg.sv -----
// shared types, constants and helpers for the decimal text to fixed-point converter
package dtf_pkg;

    localparam int INT_BITS_DEF        = 31;
    localparam int FRAC_BITS_DEF       = 32;
    localparam int MAX_FRAC_DIGITS_DEF = 9;

    localparam int QUEUE_DEPTH = 2;

    localparam int INT_ACC_W_MAX  = 31;
    localparam int FRAC_ACC_W_MAX = 30;
    localparam int DIGIT_W_MAX    = 4;

    localparam int CHAR_W     = 8;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 72;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_START,
        PH_INT,
        PH_FRAC,
        PH_BAD
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic                      neg;
        status_t                   status;
        logic [INT_ACC_W_MAX-1:0]  int_acc;
        logic [FRAC_ACC_W_MAX-1:0] frac_acc;
        logic [DIGIT_W_MAX-1:0]    frac_digits;
    } job_t;

    // powers of ten for the fraction scale
    function automatic logic [FRAC_ACC_W_MAX-1:0] pow10(input logic [DIGIT_W_MAX-1:0] d);
        logic [FRAC_ACC_W_MAX-1:0] p;
        unique case (d)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            4'd9:    p = 30'd1000000000;
            default: p = 30'd1;
        endcase
        return p;
    endfunction

endpackage

// ----- rtl/dtf_front.sv -----
// character parser: classifies each character and hands finished strings to the queue
module dtf_front
    import dtf_pkg::*;
#(
    parameter int INT_BITS        = INT_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              last_char,
    input  logic              queue_full,
    output logic              push,
    output job_t              job
);

    localparam int FAW = $clog2(pow10(DIGIT_W_MAX'(MAX_FRAC_DIGITS)));
    localparam int DCW = $clog2(MAX_FRAC_DIGITS + 1);

    phase_t               phase_reg, phase_next;
    logic                 neg_reg, neg_next;
    logic                 seen_reg, seen_next;
    logic [INT_BITS-1:0]  int_reg, int_next;
    logic                 ovf_reg, ovf_next;
    logic [FAW-1:0]       frac_reg, frac_next;
    logic [DCW-1:0]       digits_reg, digits_next;

    logic                 fire;
    logic                 is_dig;
    logic                 is_pt;
    logic [3:0]           dval;
    logic [INT_BITS+3:0]  int_prod;
    logic [FAW+3:0]       frac_prod;
    logic                 take_int;
    logic                 take_frac;

    assign in_ready = !queue_full;
    assign fire     = in_valid && in_ready;
    assign push     = fire && last_char;

    always_comb
    begin
        is_dig    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
        is_pt     = (char_code == CH_POINT) || (char_code == CH_COMMA);
        dval      = is_dig ? 4'(char_code - CH_ZERO) : 4'd0;
        int_prod  = (INT_BITS+4)'(int_reg) * (INT_BITS+4)'(10) + (INT_BITS+4)'(dval);
        frac_prod = (FAW+4)'(frac_reg) * (FAW+4)'(10) + (FAW+4)'(dval);

        phase_next  = phase_reg;
        neg_next    = neg_reg;
        seen_next   = seen_reg;
        int_next    = int_reg;
        ovf_next    = ovf_reg;
        frac_next   = frac_reg;
        digits_next = digits_reg;
        take_int    = 1'b0;
        take_frac   = 1'b0;

        unique case (phase_reg)
            PH_START:
            begin
                if (char_code == CH_MINUS || char_code == CH_PLUS)
                begin
                    neg_next   = (char_code == CH_MINUS);
                    phase_next = PH_INT;
                end
                else if (is_dig)
                begin
                    take_int   = 1'b1;
                    phase_next = PH_INT;
                end
                else if (is_pt)
                    phase_next = PH_FRAC;
                else
                    phase_next = PH_BAD;
            end
            PH_INT:
            begin
                if (is_dig)
                    take_int = 1'b1;
                else if (is_pt)
                    phase_next = PH_FRAC;
                else
                    phase_next = PH_BAD;
            end
            PH_FRAC:
            begin
                if (is_dig)
                    take_frac = 1'b1;
                else
                    phase_next = PH_BAD;
            end
            PH_BAD:
                phase_next = PH_BAD;
        endcase

        if (take_int || take_frac)
            seen_next = 1'b1;

        // overflow flag sticks and freezes the integer part
        if (take_int && !ovf_reg)
        begin
            if (int_prod[INT_BITS+3:INT_BITS] != 4'd0)
                ovf_next = 1'b1;
            else
                int_next = int_prod[INT_BITS-1:0];
        end

        if (take_frac && (digits_reg < DCW'(MAX_FRAC_DIGITS)))
        begin
            frac_next   = frac_prod[FAW-1:0];
            digits_next = digits_reg + DCW'(1);
        end

        job.neg         = neg_next;
        job.int_acc     = INT_ACC_W_MAX'(int_next);
        job.frac_acc    = FRAC_ACC_W_MAX'(frac_next);
        job.frac_digits = DIGIT_W_MAX'(digits_next);
        if (phase_next == PH_BAD || !seen_next)
            job.status = ST_INVALID;
        else if (ovf_next)
            job.status = ST_OVERFLOW;
        else
            job.status = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            neg_reg    <= 1'b0;
            seen_reg   <= 1'b0;
            int_reg    <= '0;
            ovf_reg    <= 1'b0;
            frac_reg   <= '0;
            digits_reg <= '0;
        end
        else if (fire)
        begin
            if (last_char)
            begin
                phase_reg  <= PH_START;
                neg_reg    <= 1'b0;
                seen_reg   <= 1'b0;
                int_reg    <= '0;
                ovf_reg    <= 1'b0;
                frac_reg   <= '0;
                digits_reg <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                neg_reg    <= neg_next;
                seen_reg   <= seen_next;
                int_reg    <= int_next;
                ovf_reg    <= ovf_next;
                frac_reg   <= frac_next;
                digits_reg <= digits_next;
            end
        end
    end

endmodule

// ----- rtl/dtf_queue.sv -----
// short queue of parsed strings between parser and converter
module dtf_queue
    import dtf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t           mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           do_push;
    logic           do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ----- rtl/dtf_back.sv -----
// converter: bit-serial fraction division, sign and output register
module dtf_back
    import dtf_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                queue_empty,
    input  job_t                queue_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [VALUE_W-1:0]  out_value,
    output status_t             out_status
);

    localparam int FAW = $clog2(pow10(DIGIT_W_MAX'(MAX_FRAC_DIGITS)));
    localparam int RW  = FAW + 1;
    localparam int CTW = $clog2(FRAC_BITS + 1);

    back_state_t            state_reg, state_next;
    job_t                   job_reg, job_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic [FAW-1:0]         div_reg, div_next;
    logic [FRAC_BITS-1:0]   quo_reg, quo_next;
    logic [CTW-1:0]         cnt_reg, cnt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]     out_value_reg, out_value_next;
    status_t                out_status_reg, out_status_next;

    logic                   out_free;
    logic                   load_out;
    logic [RW-1:0]          rem_dbl;
    logic [RW:0]            rem_sub;
    logic [VALUE_W-1:0]     mag;

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        rem_dbl = {rem_reg[RW-2:0], 1'b0};
        rem_sub = {1'b0, rem_dbl} - {2'b00, div_reg};
        mag     = (VALUE_W'(job_reg.int_acc) << FRAC_BITS) | VALUE_W'(quo_reg);

        state_next      = state_reg;
        job_next        = job_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        pop             = 1'b0;
        load_out        = 1'b0;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    if (queue_data.status != ST_OK)
                    begin
                        if (out_free)
                        begin
                            pop             = 1'b1;
                            load_out        = 1'b1;
                            out_value_next  = '0;
                            out_status_next = queue_data.status;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        job_next   = queue_data;
                        rem_next   = RW'(queue_data.frac_acc);
                        div_next   = FAW'(pow10(queue_data.frac_digits));
                        quo_next   = '0;
                        cnt_next   = CTW'(FRAC_BITS);
                        state_next = BK_DIV;
                    end
                end
            end
            BK_DIV:
            begin
                // one quotient bit per cycle
                if (!rem_sub[RW])
                begin
                    rem_next = rem_sub[RW-1:0];
                    quo_next = {quo_reg[FRAC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_dbl;
                    quo_next = {quo_reg[FRAC_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CTW'(1);
                if (cnt_reg == CTW'(1))
                    state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    load_out        = 1'b1;
                    out_value_next  = job_reg.neg ? (VALUE_W'(0) - mag) : mag;
                    out_status_next = ST_OK;
                    state_next      = BK_IDLE;
                end
            end
            default:
                state_next = BK_IDLE;
        endcase

        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg        <= job_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        quo_reg        <= quo_next;
        cnt_reg        <= cnt_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    a_div_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (job_reg.status == ST_OK))
        else $error("division started for a failed string");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) |-> (RW'(div_reg) > rem_reg))
        else $error("division remainder not below divisor");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg != ST_OK) |-> (out_value_reg == '0))
        else $error("failed string with nonzero value");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> ($stable(out_value_reg) && $stable(out_status_reg)))
        else $error("pending result overwritten");

endmodule

// ----- rtl/decimal_text_to_fixed_unit.sv -----
// top level of the decimal text to signed fixed-point converter
//
//  channel   dir   transaction                     payload
//  s_axis    in    one character of number text    tdata: char_code; tlast: last_char
//  m_axis    out   one converted number per text   tdata: value, status
//
//  the parser takes a character per cycle unless the 2-entry queue of finished texts is full
//  a valid number is divided bit-serially and output before the converter pops another
//  invalid or overflowing text goes from the queue to the output register with a zero value
//  the output register holds a result under m_tready low while the next one is worked on
//  s_tready falls only while the queue is full
//  rst_n clears parser state, queue pointers and the output valid flag asynchronously
module decimal_text_to_fixed_unit
    import dtf_pkg::*;
#(
    parameter int INT_BITS        = INT_BITS_DEF,
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [63:0] value, [65:64] status, rest zero
);

    logic                queue_full;
    logic                queue_empty;
    logic                push;
    logic                pop;
    job_t                push_job;
    job_t                pop_job;
    logic [VALUE_W-1:0]  value;
    status_t             status;

    dtf_front #(
        .INT_BITS        (INT_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .char_code  (s_tdata[CHAR_W-1:0]),
        .last_char  (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    dtf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (pop),
        .empty     (queue_empty),
        .pop_data  (pop_job)
    );

    dtf_back #(
        .FRAC_BITS       (FRAC_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (pop_job),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_value   (value),
        .out_status  (status)
    );

    assign m_tdata = {{(M_TDATA_W - VALUE_W - STATUS_W){1'b0}}, status, value};

endmodule

// ----- verif/tb.sv -----
// testbench for the decimal text to fixed-point converter: directed and random texts
`timescale 1ns / 1ps

module tb
    import dtf_pkg::*;
;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    typedef struct {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } number_t;

    localparam int RANDOM_CHARS = 1900;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = FRAC_BITS_DEF + 16;
    localparam longint unsigned INT_LIMIT = (64'd1 << INT_BITS_DEF) - 64'd1;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // parser state mirrored for prediction
    phase_t                    scan_phase;
    logic                      scan_neg;
    logic                      scan_seen;
    logic                      scan_ovf;
    logic [INT_ACC_W_MAX-1:0]  int_part;
    logic [FRAC_ACC_W_MAX-1:0] frac_part;
    logic [DIGIT_W_MAX-1:0]    frac_count;

    number_t pending_numbers[$];
    int      mismatches;
    bit      tx_quiet;
    bit      rx_quiet;
    bit      hold_outputs;

    decimal_text_to_fixed_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int pick_gap(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void restart_parse();
        scan_phase = PH_START;
        scan_neg   = 1'b0;
        scan_seen  = 1'b0;
        scan_ovf   = 1'b0;
        int_part   = '0;
        frac_part  = '0;
        frac_count = '0;
    endfunction

    function automatic void add_int_digit(input logic [3:0] d);
        longint unsigned grown;
        if (!scan_ovf)
        begin
            grown = 64'(int_part) * 64'd10 + 64'(d);
            if (grown > INT_LIMIT)
                scan_ovf = 1'b1;
            else
                int_part = grown[INT_ACC_W_MAX-1:0];
        end
    endfunction

    // advance the mirrored parser by one character, queue the number on the last one
    function automatic void parse_char(input logic [CHAR_W-1:0] c, input logic lst);
        logic            is_digit;
        logic            is_point;
        logic [3:0]      d;
        longint unsigned scale;
        longint unsigned mag;
        number_t         res;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_point = (c == CH_POINT) || (c == CH_COMMA);
        d = is_digit ? 4'(c - CH_ZERO) : 4'd0;
        case (scan_phase)
            PH_START:
            begin
                if (c == CH_MINUS || c == CH_PLUS)
                begin
                    scan_neg   = (c == CH_MINUS);
                    scan_phase = PH_INT;
                end
                else if (is_digit)
                begin
                    scan_seen = 1'b1;
                    add_int_digit(d);
                    scan_phase = PH_INT;
                end
                else if (is_point)
                    scan_phase = PH_FRAC;
                else
                    scan_phase = PH_BAD;
            end
            PH_INT:
            begin
                if (is_digit)
                begin
                    scan_seen = 1'b1;
                    add_int_digit(d);
                end
                else if (is_point)
                    scan_phase = PH_FRAC;
                else
                    scan_phase = PH_BAD;
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    scan_seen = 1'b1;
                    if (frac_count < MAX_FRAC_DIGITS_DEF)
                    begin
                        frac_part  = FRAC_ACC_W_MAX'(64'(frac_part) * 64'd10 + 64'(d));
                        frac_count = frac_count + 4'd1;
                    end
                end
                else
                    scan_phase = PH_BAD;
            end
            default:
            begin
            end
        endcase
        if (lst)
        begin
            res.value = '0;
            if (scan_phase == PH_BAD || !scan_seen)
                res.status = ST_INVALID;
            else if (scan_ovf)
                res.status = ST_OVERFLOW;
            else
            begin
                scale = 64'd1;
                repeat (frac_count) scale = scale * 64'd10;
                mag = (64'(int_part) << FRAC_BITS_DEF)
                    + (64'(frac_part) << FRAC_BITS_DEF) / scale;
                res.value  = scan_neg ? (64'd0 - mag) : mag;
                res.status = ST_OK;
            end
            pending_numbers.push_back(res);
            restart_parse();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [M_TDATA_W-1:0] got,
                                   input logic [M_TDATA_W-1:0] want);
        mismatches++;
        $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
    endtask

    // one character transaction on the input side
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic lst);
        int gap;
        gap = pick_gap(tx_quiet);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        parse_char(c, lst);
    endtask

    task automatic send_text(input char_q_t text);
        for (int i = 0; i < text.size(); i++)
            send_char(text[i], i == text.size() - 1);
    endtask

    task automatic send_str(input string s);
        char_q_t text;
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_text(text);
    endtask

    task automatic test_lone_sign_and_point();
        send_str("-");
        send_str(".");
        send_str("-.");
    endtask

    task automatic test_single_chars();
        send_str("9");
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b1);
    endtask

    task automatic test_signed_values();
        send_str("-0");
        send_str("+.5");
        send_str("1,25");
    endtask

    task automatic test_misplaced_chars();
        send_str("1..");
        send_str("1-");
    endtask

    task automatic test_overflow_and_long_fraction();
        send_str("3000000000");
        send_str(".0000000009");
    endtask

    // receiver holds off while short numbers keep coming, so the input must stall
    task automatic test_output_backpressure();
        hold_outputs = 1'b1;
        tx_quiet     = 1'b1;
        repeat (24) send_str("7.5");
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_texts();
        char_q_t     text;
        string       near_max;
        int          sent;
        int          kind;
        int          n_int;
        int          n_frac;
        int          p;
        bit          has_point;
        logic [7:0]  c;
        near_max = "214748364";
        sent = 0;
        while (sent < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 29) == 0)
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            text.delete();
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                // pure noise
                repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       text.push_back(CH_MINUS);
                    1:       text.push_back(CH_PLUS);
                    default: ;
                endcase
                if ($urandom_range(0, 9) == 0)
                begin
                    for (int i = 0; i < near_max.len(); i++)
                        text.push_back(near_max[i]);
                    text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                    n_int = 10;
                end
                else
                begin
                    p = $urandom_range(0, 9);
                    if (p < 2)
                        n_int = 0;
                    else if (p < 7)
                        n_int = $urandom_range(1, 4);
                    else if (p < 9)
                        n_int = $urandom_range(5, 9);
                    else
                        n_int = $urandom_range(10, 11);
                    repeat (n_int) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                has_point = (n_int == 0) || ($urandom_range(0, 2) != 0);
                n_frac = 0;
                if (has_point)
                begin
                    text.push_back($urandom_range(0, 1) ? CH_POINT : CH_COMMA);
                    p = $urandom_range(0, 9);
                    if (p < 2)
                        n_frac = 0;
                    else if (p < 7)
                        n_frac = $urandom_range(1, 5);
                    else
                        n_frac = $urandom_range(6, 12);
                    if (n_int == 0 && n_frac == 0)
                        n_frac = $urandom_range(1, 3);
                    repeat (n_frac) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                end
                if (kind < 18)
                begin
                    // broken text: a stray character replaced or inserted
                    case ($urandom_range(0, 3))
                        0:       c = 8'($urandom_range(0, 255));
                        1:       c = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
                        2:       c = $urandom_range(0, 1) ? CH_POINT : CH_COMMA;
                        default: c = 8'h00;
                    endcase
                    p = $urandom_range(0, text.size() - 1);
                    if ($urandom_range(0, 1))
                        text[p] = c;
                    else
                        text.insert(p, c);
                end
            end
            send_text(text);
            sent += text.size();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin : receiver
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_outputs)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_outputs = 1'b0;
                m_tready <= 1'b1;
            end
            else
            begin
                n = pick_gap(rx_quiet);
                if (n > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(negedge clk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        number_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_numbers.size() == 0)
                report_mismatch("result with nothing outstanding", m_tdata, '0);
            else
            begin
                want = pending_numbers.pop_front();
                if (m_tdata[VALUE_W-1:0] !== want.value)
                    report_mismatch("value", m_tdata[VALUE_W-1:0], want.value);
                if (m_tdata[VALUE_W +: STATUS_W] !== want.status)
                    report_mismatch("status", m_tdata[VALUE_W +: STATUS_W], want.status);
                if (m_tdata[M_TDATA_W-1:VALUE_W+STATUS_W] !== '0)
                    report_mismatch("padding", m_tdata[M_TDATA_W-1:VALUE_W+STATUS_W], '0);
            end
        end
    end

    initial
    begin
        #(8_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        mismatches   = 0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        hold_outputs = 1'b0;
        restart_parse();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_lone_sign_and_point();
        test_single_chars();
        test_signed_values();
        test_misplaced_chars();
        test_overflow_and_long_fraction();
        test_output_backpressure();
        test_random_texts();

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_numbers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_numbers.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
